### rtl/grid_astar_path_search_macros.svh
// assertion macros for the grid path search
`ifndef GRID_ASTAR_PATH_SEARCH_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define GAPS_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define GAPS_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define GAPS_ASSERT_IMPL(label, clk, rst_n, prop)
`define GAPS_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

### rtl/gaps_pkg.sv
// shared constants and helpers for the grid path search
package gaps_pkg;
  localparam int GRID_DIM = 8;
  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int CW = $clog2(CELLS);
  localparam int DW = 3;
  localparam logic [9:0] COST_STRAIGHT = 10'd10;
  localparam logic [9:0] COST_DIAG = 10'd14;
  localparam logic [9:0] COST_MAX = 10'd1023;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // octile distance between two in-grid cells
  function automatic logic [9:0] octile(input logic [DW-1:0] ax, input logic [DW-1:0] ay,
                                        input logic [DW-1:0] bx, input logic [DW-1:0] by);
    logic [DW-1:0] dx, dy, lo, hi;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    lo = (dx < dy) ? dx : dy;
    hi = (dx < dy) ? dy : dx;
    return COST_DIAG * 10'(lo) + COST_STRAIGHT * 10'(hi - lo);
  endfunction
endpackage

### rtl/gaps_select.sv
// sequential best-open-cell scan unit: one cell compared per cycle, behind a registered read
module gaps_select (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  scan_go,
  input  logic                  cell_open,
  input  logic [9:0]            cell_cost,
  input  logic [gaps_pkg::DW-1:0] goal_x,
  input  logic [gaps_pkg::DW-1:0] goal_y,
  output logic [gaps_pkg::CW-1:0] scan_idx,
  output logic                  scan_done,
  output logic                  best_valid,
  output logic [gaps_pkg::CW-1:0] best_idx
);
  logic                    run_r, run_nxt;
  logic [gaps_pkg::CW:0]   cnt_r, cnt_nxt;
  logic                    cmp_r, cmp_nxt;
  logic [gaps_pkg::CW-1:0] cidx_r, cidx_nxt;
  logic                    bv_r, bv_nxt;
  logic [gaps_pkg::CW-1:0] bi_r, bi_nxt;
  logic [10:0]             bf_r, bf_nxt;
  logic [9:0]              bh_r, bh_nxt;
  logic                    done_r, done_nxt;
  logic [9:0]              h;
  logic [10:0]             f;

  assign scan_idx = cnt_r[gaps_pkg::CW-1:0];
  // cell_open and cell_cost belong to the cell addressed in the previous cycle, now held in cidx_r
  assign h = gaps_pkg::octile(cidx_r[gaps_pkg::DW-1:0],
                              cidx_r[gaps_pkg::CW-1:gaps_pkg::DW], goal_x, goal_y);
  assign f = {1'b0, cell_cost} + {1'b0, h};

  // step the address and compare the arriving cell against the running best
  always_comb begin
    run_nxt = run_r; cnt_nxt = cnt_r; bv_nxt = bv_r; bi_nxt = bi_r;
    bf_nxt = bf_r; bh_nxt = bh_r; done_nxt = 1'b0;
    cmp_nxt = 1'b0; cidx_nxt = scan_idx;
    if (scan_go) begin
      run_nxt = 1'b1; cnt_nxt = '0; bv_nxt = 1'b0;
    end else begin
      if (run_r) begin
        cmp_nxt = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (gaps_pkg::CW+1)'(gaps_pkg::CELLS - 1)) run_nxt = 1'b0;
      end
      if (cmp_r) begin
        if (cell_open && (!bv_r || f < bf_r || (f == bf_r && h < bh_r))) begin
          bv_nxt = 1'b1; bi_nxt = cidx_r; bf_nxt = f; bh_nxt = h;
        end
        if (cidx_r == gaps_pkg::CW'(gaps_pkg::CELLS - 1)) done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; cnt_r <= '0; cmp_r <= 1'b0; bv_r <= 1'b0; done_r <= 1'b0;
    end else begin
      run_r <= run_nxt; cnt_r <= cnt_nxt; cmp_r <= cmp_nxt; bv_r <= bv_nxt;
      done_r <= done_nxt;
    end
    cidx_r <= cidx_nxt; bi_r <= bi_nxt; bf_r <= bf_nxt; bh_r <= bh_nxt;
  end

  assign scan_done = done_r;
  assign best_valid = bv_r;
  assign best_idx = bi_r;
endmodule

### rtl/grid_astar_path_search.sv
// top level of the grid path search: sequencer, cell stores, path output
// a blocked-flag write keeps busy high for 1 cycle; a search repeats, for each expanded
// cell, an open-set scan, a pick state and 8 neighbor steps (S_NB, S_NB2 each), then
// walks the parent chain one path cell at a time (S_WALK, S_WALK2) and emits one result
// per path cell (S_EMIT, S_ECOST, S_EMIT2); busy stays high throughout.
// throughput: one request at a time, set by the open-set scan; results cannot be stalled.
// reset (rst_n low, synchronous) clears the blocked map and all control state.
`include "grid_astar_path_search_macros.svh"
module grid_astar_path_search (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_kind,
  input  logic [2:0] in_x_pos,
  input  logic [2:0] in_y_pos,
  input  logic       in_blocked,
  input  logic [2:0] in_goal_x,
  input  logic [2:0] in_goal_y,
  output logic       out_valid,
  output logic [2:0] out_step_x,
  output logic [2:0] out_step_y,
  output logic [5:0] out_step_index,
  output logic [9:0] out_path_cost,
  output logic       out_found,
  output logic       out_last
);
  localparam int CW = gaps_pkg::CW;
  localparam int DW = gaps_pkg::DW;
  localparam int N = gaps_pkg::CELLS;

  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_SCAN = 4'd2, S_PICK = 4'd3,
                         S_NB = 4'd4, S_NB2 = 4'd5, S_WALK = 4'd6, S_WALK2 = 4'd7,
                         S_EMIT = 4'd8, S_EMIT2 = 4'd9, S_FAIL = 4'd10, S_ECOST = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [N-1:0] blk_r, open_r, closed_r;
  logic [9:0] cost_mem [N];
  logic [CW-1:0] par_mem [N];
  logic [9:0] cost_rd_r;
  logic [CW-1:0] par_rd_r;

  logic kind_r, blkin_r;
  logic [2:0] sx_r, sy_r, gx_r, gy_r;
  logic [CW-1:0] start_c, goal_c, cur_r;
  logic [9:0] cur_g_r;
  logic [2:0] nb_r;
  logic [CW-1:0] path_mem [N];
  logic [CW:0] len_r;
  logic [CW-1:0] walk_r;
  logic [CW:0] k_r;
  logic [CW-1:0] emit_c_r;
  logic [9:0] emit_cost_r;
  logic scan_open_r;
  logic [9:0] scan_cost_r;

  // scan unit
  logic scan_go, scan_done, best_valid;
  logic [CW-1:0] scan_idx, best_idx;
  gaps_select u_sel (
    .clk, .rst_n, .scan_go,
    .cell_open(scan_open_r), .cell_cost(scan_cost_r),
    .goal_x(gx_r), .goal_y(gy_r),
    .scan_idx, .scan_done, .best_valid, .best_idx
  );

  assign start_c = {sy_r, sx_r};
  assign goal_c = {gy_r, gx_r};
  assign busy = (state_r != S_IDLE);
  assign scan_go = (state_r == S_DEC && kind_r == gaps_pkg::KIND_SEARCH) ||
                   (state_r == S_NB2 && nb_r == 3'd7);

  // neighbor offsets for step nb_r
  logic signed [2:0] ddx, ddy;
  always_comb begin
    case (nb_r)
      3'd0: begin ddx = -3'sd1; ddy = -3'sd1; end
      3'd1: begin ddx = -3'sd1; ddy = 3'sd0; end
      3'd2: begin ddx = -3'sd1; ddy = 3'sd1; end
      3'd3: begin ddx = 3'sd0; ddy = -3'sd1; end
      3'd4: begin ddx = 3'sd0; ddy = 3'sd1; end
      3'd5: begin ddx = 3'sd1; ddy = -3'sd1; end
      3'd6: begin ddx = 3'sd1; ddy = 3'sd0; end
      default: begin ddx = 3'sd1; ddy = 3'sd1; end
    endcase
  end
  logic signed [4:0] nxs, nys;
  logic nb_in;
  logic [CW-1:0] nb_c;
  logic [10:0] ng_w;
  logic [9:0] ng;
  assign nxs = $signed({2'b00, cur_r[DW-1:0]}) + 5'(ddx);
  assign nys = $signed({2'b00, cur_r[CW-1:DW]}) + 5'(ddy);
  assign nb_in = nxs >= 0 && nxs < gaps_pkg::GRID_DIM && nys >= 0 && nys < gaps_pkg::GRID_DIM;
  assign nb_c = {nys[DW-1:0], nxs[DW-1:0]};
  assign ng_w = {1'b0, cur_g_r} + ((ddx != 0 && ddy != 0) ? {1'b0, gaps_pkg::COST_DIAG}
                                                          : {1'b0, gaps_pkg::COST_STRAIGHT});
  assign ng = ng_w[10] ? gaps_pkg::COST_MAX : ng_w[9:0];
  logic nb_upd;
  assign nb_upd = nb_in && !blk_r[nb_c] && !closed_r[nb_c] &&
                  (!open_r[nb_c] || ng < cost_rd_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_DEC;
      S_DEC: state_nxt = (kind_r == gaps_pkg::KIND_WRITE) ? S_IDLE : S_SCAN;
      S_SCAN: if (scan_done) state_nxt = best_valid ? S_PICK : S_FAIL;
      S_PICK: state_nxt = (best_idx == goal_c) ? S_WALK : S_NB;
      S_NB: state_nxt = S_NB2;
      S_NB2: state_nxt = (nb_r == 3'd7) ? S_SCAN : S_NB;
      S_WALK: state_nxt = S_WALK2;
      S_WALK2: state_nxt = (walk_r == start_c || len_r == (CW+1)'(N)) ? S_EMIT : S_WALK;
      S_EMIT: state_nxt = S_ECOST;
      S_ECOST: state_nxt = S_EMIT2;
      S_EMIT2: state_nxt = (k_r + 1'b1 == len_r) ? S_IDLE : S_EMIT;
      S_FAIL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; blk_r <= '0; open_r <= '0; closed_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_DEC: begin
          if (kind_r == gaps_pkg::KIND_WRITE) blk_r[start_c] <= blkin_r;
          else begin
            open_r <= N'(1) << start_c; closed_r <= '0;
          end
        end
        S_PICK: begin
          open_r[best_idx] <= 1'b0; closed_r[best_idx] <= 1'b1;
        end
        S_NB2: if (nb_upd) open_r[nb_c] <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers and memories
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      kind_r <= in_kind; blkin_r <= in_blocked; sx_r <= in_x_pos; sy_r <= in_y_pos;
      gx_r <= in_goal_x; gy_r <= in_goal_y;
    end
    if (state_r == S_DEC && kind_r == gaps_pkg::KIND_SEARCH) begin
      cost_mem[start_c] <= '0; par_mem[start_c] <= start_c;
    end
    if (state_r == S_SCAN) begin
      scan_open_r <= open_r[scan_idx]; scan_cost_r <= cost_mem[scan_idx];
    end
    if (state_r == S_PICK) begin
      cur_r <= best_idx; cur_g_r <= cost_mem[best_idx]; nb_r <= '0;
      walk_r <= goal_c; len_r <= '0;
    end
    if (state_r == S_NB) cost_rd_r <= cost_mem[nb_c];
    if (state_r == S_NB2) begin
      nb_r <= nb_r + 3'd1;
      if (nb_upd) begin
        cost_mem[nb_c] <= ng; par_mem[nb_c] <= cur_r;
      end
    end
    if (state_r == S_WALK) begin
      path_mem[len_r[CW-1:0]] <= walk_r; par_rd_r <= par_mem[walk_r]; len_r <= len_r + 1'b1;
      k_r <= '0;
    end
    if (state_r == S_WALK2) walk_r <= par_rd_r;
    if (state_r == S_EMIT) emit_c_r <= path_mem[CW'(len_r - 1'b1 - k_r)];
    if (state_r == S_ECOST) emit_cost_r <= cost_mem[emit_c_r];
    if (state_r == S_EMIT2) k_r <= k_r + 1'b1;
  end

  // result ports
  assign out_valid = (state_r == S_EMIT2) || (state_r == S_FAIL);
  assign out_found = (state_r == S_EMIT2);
  assign out_step_x = out_found ? emit_c_r[DW-1:0] : 3'd0;
  assign out_step_y = out_found ? emit_c_r[CW-1:DW] : 3'd0;
  assign out_step_index = out_found ? k_r[CW-1:0] : 6'd0;
  assign out_path_cost = out_found ? emit_cost_r : 10'd0;
  assign out_last = (state_r == S_FAIL) || (out_found && k_r + 1'b1 == len_r);

  `GAPS_ASSERT_IMPL(a_busy_when_out, clk, rst_n, out_valid |-> busy)
  `GAPS_ASSERT_NEVER(a_found_fail, clk, rst_n, out_found && state_r == S_FAIL)
  `GAPS_ASSERT_IMPL(a_fail_last, clk, rst_n, (out_valid && !out_found) |-> out_last)
  `GAPS_ASSERT_IMPL(a_last_idle, clk, rst_n, (out_valid && out_last) |=> !busy)
endmodule

### tb/tb_top.sv
// testbench for the grid path search: directed table, random map edits and searches
module tb_top;
  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_kind;
  logic [2:0] in_x_pos, in_y_pos, in_goal_x, in_goal_y;
  logic       in_blocked;
  logic       out_valid;
  logic [2:0] out_step_x, out_step_y;
  logic [5:0] out_step_index;
  logic [9:0] out_path_cost;
  logic       out_found, out_last;

  grid_astar_path_search dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_x_pos(in_x_pos), .in_y_pos(in_y_pos),
    .in_blocked(in_blocked), .in_goal_x(in_goal_x), .in_goal_y(in_goal_y),
    .out_valid(out_valid), .out_step_x(out_step_x), .out_step_y(out_step_y),
    .out_step_index(out_step_index), .out_path_cost(out_path_cost),
    .out_found(out_found), .out_last(out_last)
  );

  typedef struct packed {
    logic       kind;
    logic [2:0] x;
    logic [2:0] y;
    logic       blk;
    logic [2:0] gx;
    logic [2:0] gy;
  } request_t;

  typedef struct packed {
    logic [2:0] sx;
    logic [2:0] sy;
    logic [5:0] idx;
    logic [9:0] cost;
    logic       found;
    logic       last;
  } step_t;

  // directed row: request plus an optional typed-in first step
  typedef struct packed {
    request_t req;
    logic     has_fixed;
    step_t    fixed;
  } row_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;

  // predictor state
  logic       map_blk [gaps_pkg::CELLS];
  logic [9:0] g_cost  [gaps_pkg::CELLS];
  logic [5:0] parent  [gaps_pkg::CELLS];
  logic       is_open [gaps_pkg::CELLS];
  logic       is_closed [gaps_pkg::CELLS];

  step_t path_queue[$];
  int    error_count;
  int    idle_cycles;
  int    items_sent;

  function automatic logic [9:0] dist_to_goal(int ax, int ay, int bx, int by);
    int dx, dy, lo, hi;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    lo = (dx < dy) ? dx : dy;
    hi = (dx < dy) ? dy : dx;
    return 10'(14 * lo + 10 * (hi - lo));
  endfunction

  // predict the path steps for one search request and push them; a write request only updates the map
  task automatic predict_search(input request_t r);
    int src, dst, cur, bf, bh, h, f, nx, ny, n, ng, len, p;
    int route[64];
    step_t s;
    if (r.kind == gaps_pkg::KIND_WRITE) begin
      map_blk[int'(r.y) * gaps_pkg::GRID_DIM + int'(r.x)] = r.blk;
      return;
    end
    for (int c = 0; c < gaps_pkg::CELLS; c++) begin
      is_open[c] = 0;
      is_closed[c] = 0;
    end
    src = int'(r.y) * gaps_pkg::GRID_DIM + int'(r.x);
    dst = int'(r.gy) * gaps_pkg::GRID_DIM + int'(r.gx);
    g_cost[src] = 0;
    parent[src] = 6'(src);
    is_open[src] = 1;
    forever begin
      cur = -1;
      bf = 0;
      bh = 0;
      for (int c = 0; c < gaps_pkg::CELLS; c++) begin
        if (!is_open[c]) continue;
        h = dist_to_goal(c % gaps_pkg::GRID_DIM, c / gaps_pkg::GRID_DIM, r.gx, r.gy);
        f = g_cost[c] + h;
        if (cur < 0 || f < bf || (f == bf && h < bh)) begin
          cur = c;
          bf = f;
          bh = h;
        end
      end
      if (cur < 0) begin
        s = '0;
        s.last = 1;
        path_queue.push_back(s);
        return;
      end
      is_open[cur] = 0;
      is_closed[cur] = 1;
      if (cur == dst) begin
        len = 0;
        p = dst;
        while (len < 64) begin
          route[len] = p;
          len++;
          if (p == src) break;
          p = parent[p];
        end
        for (int k = 0; k < len; k++) begin
          p = route[len - 1 - k];
          s.sx = 3'(p % gaps_pkg::GRID_DIM);
          s.sy = 3'(p / gaps_pkg::GRID_DIM);
          s.idx = 6'(k);
          s.cost = g_cost[p];
          s.found = 1;
          s.last = (k == len - 1);
          path_queue.push_back(s);
        end
        return;
      end
      // relax the eight neighbors
      for (int dx = -1; dx <= 1; dx++) begin
        for (int dy = -1; dy <= 1; dy++) begin
          if (dx == 0 && dy == 0) continue;
          nx = cur % gaps_pkg::GRID_DIM + dx;
          ny = cur / gaps_pkg::GRID_DIM + dy;
          if (nx < 0 || nx >= gaps_pkg::GRID_DIM || ny < 0 || ny >= gaps_pkg::GRID_DIM)
            continue;
          n = ny * gaps_pkg::GRID_DIM + nx;
          if (map_blk[n] || is_closed[n]) continue;
          ng = g_cost[cur] + ((dx != 0 && dy != 0) ? 14 : 10);
          if (ng > 1023) ng = 1023;
          if (!is_open[n] || ng < g_cost[n]) begin
            g_cost[n] = 10'(ng);
            parent[n] = 6'(cur);
            is_open[n] = 1;
          end
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin
    step_t w;
    if (rst_n && out_valid) begin
      if (path_queue.size() == 0) begin
        report_mismatch("unexpected step", 1, 0);
      end else begin
        w = path_queue.pop_front();
        if (out_step_x != w.sx) report_mismatch("step_x", out_step_x, w.sx);
        if (out_step_y != w.sy) report_mismatch("step_y", out_step_y, w.sy);
        if (out_step_index != w.idx) report_mismatch("step_index", out_step_index, w.idx);
        if (out_path_cost != w.cost) report_mismatch("path_cost", out_path_cost, w.cost);
        if (out_found != w.found) report_mismatch("found", out_found, w.found);
        if (out_last != w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  // watchdog on cycles without any accepted request or step
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // drive one request, predicting and checking any fixed first step
  task automatic send_request(input request_t r, input bit random_gap,
                              input bit has_fixed, input step_t fixed);
    int gap;
    gap = random_gap ? $urandom_range(0, 8) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    // drop start while idling between requests
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_kind <= r.kind;
    in_x_pos <= r.x;
    in_y_pos <= r.y;
    in_blocked <= r.blk;
    in_goal_x <= r.gx;
    in_goal_y <= r.gy;
    do @(posedge clk); while (busy);
    predict_search(r);
    if (has_fixed && path_queue.size() > 0 && path_queue[0] != fixed) begin
      report_mismatch("directed first step", int'(path_queue[0]), int'(fixed));
    end
    items_sent++;
  endtask

  function automatic request_t mk(logic k, int x, int y, logic b, int gx, int gy);
    request_t r;
    r.kind = k;
    r.x = 3'(x);
    r.y = 3'(y);
    r.blk = b;
    r.gx = 3'(gx);
    r.gy = 3'(gy);
    return r;
  endfunction

  function automatic step_t st(int x, int y, int i, int c, logic fd, logic l);
    step_t s;
    s.sx = 3'(x);
    s.sy = 3'(y);
    s.idx = 6'(i);
    s.cost = 10'(c);
    s.found = fd;
    s.last = l;
    return s;
  endfunction

  row_t directed[$];
  request_t rq;

  initial begin
    error_count = 0;
    items_sent = 0;
    for (int c = 0; c < gaps_pkg::CELLS; c++) map_blk[c] = 0;
    rst_n = 0;
    start = 0;
    in_kind = 0;
    in_x_pos = 0;
    in_y_pos = 0;
    in_blocked = 0;
    in_goal_x = 0;
    in_goal_y = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed table: extremes, start on goal, blocked goal/start, walls, corner cuts
    directed = '{
      '{mk(gaps_pkg::KIND_SEARCH, 0, 0, 0, 0, 0), 1, st(0, 0, 0, 0, 1, 1)},
      '{mk(gaps_pkg::KIND_SEARCH, 7, 7, 1, 7, 7), 1, st(7, 7, 0, 0, 1, 1)},
      '{mk(gaps_pkg::KIND_SEARCH, 0, 0, 0, 7, 7), 1, st(0, 0, 0, 0, 1, 0)},
      '{mk(gaps_pkg::KIND_SEARCH, 7, 0, 0, 0, 7), 0, '0},
      '{mk(gaps_pkg::KIND_SEARCH, 0, 3, 0, 7, 3), 0, '0},
      '{mk(gaps_pkg::KIND_WRITE, 7, 7, 1, 0, 0), 0, '0},
      '{mk(gaps_pkg::KIND_SEARCH, 0, 0, 0, 7, 7), 1, st(0, 0, 0, 0, 0, 1)},
      '{mk(gaps_pkg::KIND_SEARCH, 7, 7, 0, 7, 7), 1, st(7, 7, 0, 0, 1, 1)},
      '{mk(gaps_pkg::KIND_SEARCH, 7, 7, 0, 0, 0), 0, '0},
      '{mk(gaps_pkg::KIND_WRITE, 7, 7, 0, 7, 7), 0, '0},
      '{mk(gaps_pkg::KIND_WRITE, 1, 0, 1, 0, 0), 0, '0},
      '{mk(gaps_pkg::KIND_WRITE, 0, 1, 1, 0, 0), 0, '0},
      '{mk(gaps_pkg::KIND_SEARCH, 0, 0, 0, 1, 1), 0, '0},
      '{mk(gaps_pkg::KIND_WRITE, 1, 1, 1, 0, 0), 0, '0},
      '{mk(gaps_pkg::KIND_SEARCH, 0, 0, 0, 5, 5), 1, st(0, 0, 0, 0, 0, 1)},
      '{mk(gaps_pkg::KIND_SEARCH, 4, 4, 0, 0, 0), 1, st(0, 0, 0, 0, 0, 1)},
      '{mk(gaps_pkg::KIND_WRITE, 0, 1, 0, 0, 0), 0, '0},
      '{mk(gaps_pkg::KIND_WRITE, 1, 0, 0, 0, 0), 0, '0},
      '{mk(gaps_pkg::KIND_WRITE, 1, 1, 0, 0, 0), 0, '0}
    };
    // a wall across column 4 with one gap at row 7
    for (int y = 0; y < 7; y++)
      directed.push_back(row_t'{mk(gaps_pkg::KIND_WRITE, 4, y, 1, 0, 0), 0, '0});
    directed.push_back(row_t'{mk(gaps_pkg::KIND_SEARCH, 0, 0, 0, 7, 0), 0, '0});
    directed.push_back(row_t'{mk(gaps_pkg::KIND_WRITE, 4, 7, 1, 0, 0), 0, '0});
    directed.push_back(row_t'{mk(gaps_pkg::KIND_SEARCH, 0, 0, 0, 7, 0), 1,
                              st(0, 0, 0, 0, 0, 1)});
    foreach (directed[i])
      send_request(directed[i].req, 1, directed[i].has_fixed, directed[i].fixed);

    // let the map edits settle, then clear the map
    start <= 0;
    do @(posedge clk); while (path_queue.size() != 0 || busy);
    for (int y = 0; y < 8; y++) begin
      send_request(mk(gaps_pkg::KIND_WRITE, 4, y, 0, 0, 0), 1, 0, '0);
    end

    // random phase: mostly searches over a sparse map, with map edits mixed in
    for (int i = 0; i < 115; i++) begin
      if (i == 57) begin
        // hold off until every outstanding step has arrived
        start <= 0;
        do @(posedge clk); while (path_queue.size() != 0);
      end
      rq = request_t'(14'($urandom));
      if ($urandom_range(0, 2) == 0) begin
        rq.kind = gaps_pkg::KIND_WRITE;
        rq.blk = ($urandom_range(0, 99) < 35);
      end else begin
        rq.kind = gaps_pkg::KIND_SEARCH;
      end
      send_request(rq, ($urandom_range(0, 4) != 0), 0, '0);
    end

    // drain
    start <= 0;
    while (path_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
